// ===== hdl/ert_pkg.sv =====
// Shared types and constants for the echo round-trip tracker.
// Used by ert_table and echo_rtt_tracker_unit; no dependencies.
`default_nettype none

package ert_pkg;

    localparam int MODE_W    = 2;
    localparam int SEQ_W     = 16;
    localparam int TIME_W    = 48;
    localparam int DLY_W     = 32;
    localparam int CNT_OUT_W = 7;
    localparam int LOSS_W    = 7;

    localparam logic [MODE_W-1:0] MODE_SEND    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REPLY   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUMMARY = 2'd2;

    localparam logic [LOSS_W-1:0] PCT_FULL = 7'd100;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] sent_time;
        logic [DLY_W-1:0]  delay;
        logic              replied;
    } ert_entry_t;

endpackage

`default_nettype wire

// ===== hdl/echo_rtt_tracker_unit.sv =====
// Echo round-trip tracker top level: sequencer, table and shared divider.
// Depends on ert_pkg, ert_table and ert_divider.
//
// Usage:
//   Input channel (in_valid/in_ready) carries mode, seq_number, time_us.
//   Mode 0 stores a request, mode 1 matches a reply against the newest
//   unanswered entry with that sequence, mode 2 returns statistics.
//   Output channel (out_valid/out_ready) returns exactly one result per
//   transaction; the result sits in an output register until taken.
//   One transaction at a time: in_ready is high only while the sequencer
//   is idle. A reply scans the stored requests with one table read per
//   cycle, newest first, and stops at the first match. A summary makes
//   two table passes through the single read port and three bit-serial
//   divisions; with no replies stored it makes one pass and no division.
//   If the receiver stalls, the finished result waits in the sequencer
//   until the output register frees up.
//   Reset empties the table (count to zero) and drops any pending result.
`default_nettype none

module echo_rtt_tracker_unit #(
    parameter int MAX_PINGS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ert_pkg::MODE_W-1:0]     mode,
    input  logic [ert_pkg::SEQ_W-1:0]      seq_number,
    input  logic [ert_pkg::TIME_W-1:0]     time_us,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           accepted,
    output logic [ert_pkg::DLY_W-1:0]      delay_us,
    output logic [ert_pkg::CNT_OUT_W-1:0]  sent_count,
    output logic [ert_pkg::CNT_OUT_W-1:0]  reply_count,
    output logic [ert_pkg::DLY_W-1:0]      min_delay_us,
    output logic [ert_pkg::DLY_W-1:0]      max_delay_us,
    output logic [ert_pkg::DLY_W-1:0]      mean_delay_us,
    output logic [ert_pkg::DLY_W-1:0]      mean_deviation_us,
    output logic [ert_pkg::LOSS_W-1:0]     loss_percent
);

    import ert_pkg::*;

    localparam int IDX_W = $clog2(MAX_PINGS);
    localparam int CNT_W = $clog2(MAX_PINGS + 1);
    localparam int SUM_W = DLY_W + CNT_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SEND     = 4'd1;
    localparam logic [3:0] S_RSCAN    = 4'd2;
    localparam logic [3:0] S_RWRITE   = 4'd3;
    localparam logic [3:0] S_SCAN1    = 4'd4;
    localparam logic [3:0] S_DIV_MEAN = 4'd5;
    localparam logic [3:0] S_SCAN2    = 4'd6;
    localparam logic [3:0] S_DIV_DEV  = 4'd7;
    localparam logic [3:0] S_DIV_LOSS = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0]            state_reg, state_next;
    logic [CNT_W-1:0]      slot_cnt_reg, slot_cnt_next;
    logic [CNT_W-1:0]      left_reg, left_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  out_valid_reg, out_valid_next;

    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [SEQ_W-1:0]      seq_reg, seq_next;
    logic [TIME_W-1:0]     time_reg, time_next;
    logic                  acc_reg, acc_next;
    logic [DLY_W-1:0]      dly_reg, dly_next;
    ert_entry_t            hit_reg, hit_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [CNT_W-1:0]      rcvd_reg, rcvd_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [DLY_W-1:0]      mn_reg, mn_next;
    logic [DLY_W-1:0]      mx_reg, mx_next;
    logic [DLY_W-1:0]      mean_reg, mean_next;
    logic [SUM_W-1:0]      devsum_reg, devsum_next;
    logic [DLY_W-1:0]      devq_reg, devq_next;
    logic [LOSS_W-1:0]     loss_reg, loss_next;

    logic                  accepted_reg, accepted_next;
    logic [DLY_W-1:0]      delay_reg, delay_next;
    logic [CNT_OUT_W-1:0]  sent_count_reg, sent_count_next;
    logic [CNT_OUT_W-1:0]  reply_count_reg, reply_count_next;
    logic [DLY_W-1:0]      min_reg, min_next;
    logic [DLY_W-1:0]      max_reg, max_next;
    logic [DLY_W-1:0]      mean_out_reg, mean_out_next;
    logic [DLY_W-1:0]      dev_out_reg, dev_out_next;
    logic [LOSS_W-1:0]     loss_out_reg, loss_out_next;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    ert_entry_t            wr_data;
    logic                  rd_en;
    ert_entry_t            rd_data;

    logic                  div_start;
    logic [SUM_W-1:0]      div_dvd;
    logic [CNT_W-1:0]      div_dvs;
    logic                  div_busy;
    logic                  div_done;
    logic [SUM_W-1:0]      div_quo;

    logic [TIME_W:0]       elapsed;
    logic [DLY_W-1:0]      rtt_sat;
    logic [DLY_W-1:0]      abs_dev;
    logic [CNT_W-1:0]      cnt_m1;
    logic [SUM_W-1:0]      loss_dvd;
    logic [CNT_W+CNT_OUT_W-1:0] sent_ext;
    logic [CNT_W+CNT_OUT_W-1:0] rcvd_ext;
    logic                  scanning;
    logic                  scan_end;
    logic                  is_summary;
    logic                  has_reply;

    ert_table #(
        .DEPTH  (MAX_PINGS),
        .ADDR_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    ert_divider #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign elapsed  = {1'b0, time_reg} - {1'b0, rd_data.sent_time};
    assign rtt_sat  = elapsed[TIME_W] ? '0 :
                      (|elapsed[TIME_W-1:DLY_W]) ? '1 : elapsed[DLY_W-1:0];
    assign abs_dev  = (rd_data.delay >= mean_reg) ? (rd_data.delay - mean_reg)
                                                  : (mean_reg - rd_data.delay);
    assign cnt_m1   = slot_cnt_reg - 1'b1;
    assign loss_dvd = SUM_W'(rcvd_reg) * SUM_W'(PCT_FULL);
    assign sent_ext = {{CNT_OUT_W{1'b0}}, slot_cnt_reg};
    assign rcvd_ext = {{CNT_OUT_W{1'b0}}, rcvd_reg};
    assign scanning = (state_reg == S_RSCAN) || (state_reg == S_SCAN1) ||
                      (state_reg == S_SCAN2);
    assign scan_end = (left_reg == '0) && !rd_vld_reg;
    assign is_summary = (mode_reg == MODE_SUMMARY);
    assign has_reply  = (rcvd_reg != '0);

    always_comb
    begin
        state_next       = state_reg;
        slot_cnt_next    = slot_cnt_reg;
        left_next        = left_reg;
        idx_next         = idx_reg;
        rd_idx_next      = idx_reg;
        out_valid_next   = out_valid_reg;
        mode_next        = mode_reg;
        seq_next         = seq_reg;
        time_next        = time_reg;
        acc_next         = acc_reg;
        dly_next         = dly_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        rcvd_next        = rcvd_reg;
        sum_next         = sum_reg;
        mn_next          = mn_reg;
        mx_next          = mx_reg;
        mean_next        = mean_reg;
        devsum_next      = devsum_reg;
        devq_next        = devq_reg;
        loss_next        = loss_reg;
        accepted_next    = accepted_reg;
        delay_next       = delay_reg;
        sent_count_next  = sent_count_reg;
        reply_count_next = reply_count_reg;
        min_next         = min_reg;
        max_next         = max_reg;
        mean_out_next    = mean_out_reg;
        dev_out_next     = dev_out_reg;
        loss_out_next    = loss_out_reg;
        wr_en            = 1'b0;
        wr_addr          = slot_cnt_reg[IDX_W-1:0];
        wr_data          = '{seq: seq_reg, sent_time: time_reg, delay: '0, replied: 1'b0};
        rd_en            = 1'b0;
        div_start        = 1'b0;
        div_dvd          = sum_reg;
        div_dvs          = rcvd_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // advance the table read pointer while a pass is running
        if (scanning && (left_reg != '0))
        begin
            rd_en     = 1'b1;
            left_next = left_reg - 1'b1;
            idx_next  = (state_reg == S_RSCAN) ? idx_reg - 1'b1 : idx_reg + 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next = mode;
                    seq_next  = seq_number;
                    time_next = time_us;
                    acc_next  = 1'b0;
                    dly_next  = '0;
                    unique case (mode)
                        MODE_SEND:
                        begin
                            state_next = S_SEND;
                        end
                        MODE_REPLY:
                        begin
                            left_next  = slot_cnt_reg;
                            idx_next   = cnt_m1[IDX_W-1:0];
                            state_next = S_RSCAN;
                        end
                        MODE_SUMMARY:
                        begin
                            acc_next    = 1'b1;
                            left_next   = slot_cnt_reg;
                            idx_next    = '0;
                            rcvd_next   = '0;
                            sum_next    = '0;
                            mn_next     = '1;
                            mx_next     = '0;
                            devsum_next = '0;
                            loss_next   = PCT_FULL;
                            state_next  = S_SCAN1;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SEND:
            begin
                if (slot_cnt_reg < CNT_W'(MAX_PINGS))
                begin
                    wr_en         = 1'b1;
                    slot_cnt_next = slot_cnt_reg + 1'b1;
                    acc_next      = 1'b1;
                end
                state_next = S_DONE;
            end
            S_RSCAN:
            begin
                if (rd_vld_reg && !rd_data.replied && (rd_data.seq == seq_reg))
                begin
                    hit_next         = rd_data;
                    hit_next.delay   = rtt_sat;
                    hit_next.replied = 1'b1;
                    hit_idx_next     = rd_idx_reg;
                    acc_next         = 1'b1;
                    dly_next         = rtt_sat;
                    state_next       = S_RWRITE;
                end
                else if (scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_RWRITE:
            begin
                wr_en      = 1'b1;
                wr_addr    = hit_idx_reg;
                wr_data    = hit_reg;
                state_next = S_DONE;
            end
            S_SCAN1:
            begin
                if (rd_vld_reg && rd_data.replied)
                begin
                    rcvd_next = rcvd_reg + 1'b1;
                    sum_next  = sum_reg + SUM_W'(rd_data.delay);
                    if (rd_data.delay < mn_reg)
                    begin
                        mn_next = rd_data.delay;
                    end
                    if (rd_data.delay > mx_reg)
                    begin
                        mx_next = rd_data.delay;
                    end
                end
                else if (scan_end)
                begin
                    if (has_reply)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV_MEAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DIV_MEAN:
            begin
                if (div_done)
                begin
                    mean_next  = div_quo[DLY_W-1:0];
                    left_next  = slot_cnt_reg;
                    idx_next   = '0;
                    state_next = S_SCAN2;
                end
            end
            S_SCAN2:
            begin
                if (rd_vld_reg && rd_data.replied)
                begin
                    devsum_next = devsum_reg + SUM_W'(abs_dev);
                end
                else if (scan_end)
                begin
                    div_start  = 1'b1;
                    div_dvd    = devsum_reg;
                    state_next = S_DIV_DEV;
                end
            end
            S_DIV_DEV:
            begin
                if (div_done)
                begin
                    devq_next  = div_quo[DLY_W-1:0];
                    div_start  = 1'b1;
                    div_dvd    = loss_dvd;
                    div_dvs    = slot_cnt_reg;
                    state_next = S_DIV_LOSS;
                end
            end
            S_DIV_LOSS:
            begin
                if (div_done)
                begin
                    loss_next  = PCT_FULL - div_quo[LOSS_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    accepted_next    = acc_reg;
                    delay_next       = dly_reg;
                    sent_count_next  = is_summary ? sent_ext[CNT_OUT_W-1:0] : '0;
                    reply_count_next = is_summary ? rcvd_ext[CNT_OUT_W-1:0] : '0;
                    min_next         = (is_summary && has_reply) ? mn_reg : '0;
                    max_next         = (is_summary && has_reply) ? mx_reg : '0;
                    mean_out_next    = (is_summary && has_reply) ? mean_reg : '0;
                    dev_out_next     = (is_summary && has_reply) ? devq_reg : '0;
                    loss_out_next    = is_summary ? loss_reg : '0;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rd_vld_next = rd_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_cnt_reg  <= '0;
            left_reg      <= '0;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_cnt_reg  <= slot_cnt_next;
            left_reg      <= left_next;
            idx_reg       <= idx_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg      <= rd_idx_next;
        mode_reg        <= mode_next;
        seq_reg         <= seq_next;
        time_reg        <= time_next;
        acc_reg         <= acc_next;
        dly_reg         <= dly_next;
        hit_reg         <= hit_next;
        hit_idx_reg     <= hit_idx_next;
        rcvd_reg        <= rcvd_next;
        sum_reg         <= sum_next;
        mn_reg          <= mn_next;
        mx_reg          <= mx_next;
        mean_reg        <= mean_next;
        devsum_reg      <= devsum_next;
        devq_reg        <= devq_next;
        loss_reg        <= loss_next;
        accepted_reg    <= accepted_next;
        delay_reg       <= delay_next;
        sent_count_reg  <= sent_count_next;
        reply_count_reg <= reply_count_next;
        min_reg         <= min_next;
        max_reg         <= max_next;
        mean_out_reg    <= mean_out_next;
        dev_out_reg     <= dev_out_next;
        loss_out_reg    <= loss_out_next;
    end

    assign in_ready          = (state_reg == S_IDLE);
    assign out_valid         = out_valid_reg;
    assign accepted          = accepted_reg;
    assign delay_us          = delay_reg;
    assign sent_count        = sent_count_reg;
    assign reply_count       = reply_count_reg;
    assign min_delay_us      = min_reg;
    assign max_delay_us      = max_reg;
    assign mean_delay_us     = mean_out_reg;
    assign mean_deviation_us = dev_out_reg;
    assign loss_percent      = loss_out_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_cnt_reg <= CNT_W'(MAX_PINGS))
        else $error("table count exceeds capacity");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_send_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEND) && (slot_cnt_reg < CNT_W'(MAX_PINGS))
        |=> slot_cnt_reg == CNT_W'($past(slot_cnt_reg) + 1'b1))
        else $error("stored send did not advance the table count");

    a_table_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == S_SEND) || (state_reg == S_RWRITE)))
        else $error("table written outside send or reply update");
`endif

endmodule

`default_nettype wire

// ===== hdl/ert_divider.sv =====
// Shared bit-serial restoring divider, one quotient bit per cycle.
// Standalone; used by echo_rtt_tracker_unit for mean, deviation and loss.
`default_nettype none

module ert_divider #(
    parameter int DVD_W = 39,
    parameter int DVS_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DVS_W:0]    rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;

    logic [DVS_W:0]    rem_shift;
    logic [DVS_W:0]    rem_sub;
    logic              fits;

    assign rem_shift = {rem_reg[DVS_W-1:0], quo_reg[DVD_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};
    assign fits      = rem_shift >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DVD_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DVD_W-2:0], fits};
            rem_next  = fits ? rem_sub : rem_shift;
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hdl/ert_table.sv =====
// Request table: one write port, one registered read port.
// Depends on ert_pkg for the entry layout.
`default_nettype none

module ert_table #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  ert_pkg::ert_entry_t wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output ert_pkg::ert_entry_t rd_data
);

    import ert_pkg::*;

    ert_entry_t mem [DEPTH];
    ert_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== tb/echo_rtt_tracker_checker.sv =====
// Result checker for echo_rtt_tracker_unit: watches both channels, keeps its own
// echo table and statistics, and compares every result field by field.
// Depends on ert_pkg.
`default_nettype none

module echo_rtt_tracker_checker #(
    parameter int MAX_PINGS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [ert_pkg::MODE_W-1:0]     mode,
    input  logic [ert_pkg::SEQ_W-1:0]      seq_number,
    input  logic [ert_pkg::TIME_W-1:0]     time_us,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           accepted,
    input  logic [ert_pkg::DLY_W-1:0]      delay_us,
    input  logic [ert_pkg::CNT_OUT_W-1:0]  sent_count,
    input  logic [ert_pkg::CNT_OUT_W-1:0]  reply_count,
    input  logic [ert_pkg::DLY_W-1:0]      min_delay_us,
    input  logic [ert_pkg::DLY_W-1:0]      max_delay_us,
    input  logic [ert_pkg::DLY_W-1:0]      mean_delay_us,
    input  logic [ert_pkg::DLY_W-1:0]      mean_deviation_us,
    input  logic [ert_pkg::LOSS_W-1:0]     loss_percent,
    output int                             mismatch_total,
    output int                             pending_results,
    output int                             stored_sends,
    output int                             refused_sends,
    output int                             matched_replies,
    output int                             summaries_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    import ert_pkg::*;

    typedef struct packed {
        logic                 ok;
        logic [DLY_W-1:0]     rtt;
        logic [CNT_OUT_W-1:0] n_sent;
        logic [CNT_OUT_W-1:0] n_replied;
        logic [DLY_W-1:0]     lo;
        logic [DLY_W-1:0]     hi;
        logic [DLY_W-1:0]     avg;
        logic [DLY_W-1:0]     dev;
        logic [LOSS_W-1:0]    loss;
    } rtt_result_t;

    localparam longint unsigned DLY_SAT = 64'hFFFF_FFFF;

    logic [SEQ_W-1:0]  seq_tab [MAX_PINGS];
    logic [TIME_W-1:0] sent_at [MAX_PINGS];
    logic [DLY_W-1:0]  rtt_tab [MAX_PINGS];
    bit                answered [MAX_PINGS];
    int unsigned       fill;
    int                result_no;
    rtt_result_t       expected_q [$];

    function automatic rtt_result_t track_echo(logic [MODE_W-1:0] m, logic [SEQ_W-1:0] s,
                                               logic [TIME_W-1:0] t);
        rtt_result_t     r;
        longint unsigned d;
        longint unsigned total;
        longint unsigned spread;
        longint unsigned avg;
        int unsigned     got;
        int              idx;
        bit              hit;
        r = '0;
        case (m)
            MODE_SEND: begin
                if (fill < MAX_PINGS) begin
                    seq_tab[fill]  = s;
                    sent_at[fill]  = t;
                    rtt_tab[fill]  = '0;
                    answered[fill] = 1'b0;
                    fill++;
                    r.ok = 1'b1;
                    stored_sends++;
                end else begin
                    refused_sends++;
                end
            end
            MODE_REPLY: begin
                hit = 1'b0;
                for (idx = int'(fill) - 1; idx >= 0 && !hit; idx--) begin
                    if (!answered[idx] && seq_tab[idx] == s) begin
                        hit = 1'b1;
                        d = (64'(t) > 64'(sent_at[idx])) ? 64'(t) - 64'(sent_at[idx]) : 64'd0;
                        if (d > DLY_SAT)
                            d = DLY_SAT;
                        answered[idx] = 1'b1;
                        rtt_tab[idx]  = d[DLY_W-1:0];
                        r.ok  = 1'b1;
                        r.rtt = d[DLY_W-1:0];
                        matched_replies++;
                    end
                end
            end
            MODE_SUMMARY: begin
                r.ok  = 1'b1;
                got   = 0;
                total = 0;
                r.lo  = '1;
                r.hi  = '0;
                for (idx = 0; idx < int'(fill); idx++) begin
                    if (answered[idx]) begin
                        got++;
                        if (rtt_tab[idx] < r.lo)
                            r.lo = rtt_tab[idx];
                        if (rtt_tab[idx] > r.hi)
                            r.hi = rtt_tab[idx];
                        total += 64'(rtt_tab[idx]);
                    end
                end
                r.n_sent    = fill[CNT_OUT_W-1:0];
                r.n_replied = got[CNT_OUT_W-1:0];
                if (got == 0) begin
                    r.lo   = '0;
                    r.hi   = '0;
                    r.loss = PCT_FULL;
                end else begin
                    avg    = total / got;
                    spread = 0;
                    for (idx = 0; idx < int'(fill); idx++) begin
                        if (answered[idx]) begin
                            d = 64'(rtt_tab[idx]);
                            spread += (d > avg) ? d - avg : avg - d;
                        end
                    end
                    r.avg  = avg[DLY_W-1:0];
                    d      = spread / got;
                    r.dev  = d[DLY_W-1:0];
                    d      = (64'(got) * 64'(PCT_FULL)) / fill;
                    r.loss = PCT_FULL - d[LOSS_W-1:0];
                end
                summaries_seen++;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned seen);
        if (want != seen) begin
            mismatch_total++;
            if (mismatch_total <= 10)
                $display("result %0d: %s expected %0d, got %0d", result_no, name, want, seen);
        end
    endtask

    initial begin
        fill = 0;
        foreach (answered[i])
            answered[i] = 1'b0;
    end

    always @(posedge clk) begin
        rtt_result_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                        $display("result %0d arrived with no transaction outstanding",
                                 result_no);
                end else begin
                    want = expected_q.pop_front();
                    check_field("accepted", want.ok, accepted);
                    check_field("delay_us", want.rtt, delay_us);
                    check_field("sent_count", want.n_sent, sent_count);
                    check_field("reply_count", want.n_replied, reply_count);
                    check_field("min_delay_us", want.lo, min_delay_us);
                    check_field("max_delay_us", want.hi, max_delay_us);
                    check_field("mean_delay_us", want.avg, mean_delay_us);
                    check_field("mean_deviation_us", want.dev, mean_deviation_us);
                    check_field("loss_percent", want.loss, loss_percent);
                end
                result_no++;
            end
            if (in_valid && in_ready)
                expected_q.push_back(track_echo(mode, seq_number, time_us));
            pending_results = expected_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/echo_rtt_tracker_unit_test.sv =====
// Top of the echo_rtt_tracker_unit testbench: clock, reset, stimulus and verdict.
// Depends on ert_pkg, echo_rtt_tracker_unit and echo_rtt_tracker_checker.
`default_nettype none

module echo_rtt_tracker_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ert_pkg::*;

    localparam int MAX_PINGS = 64;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [TIME_W-1:0] TIME_TOP = '1;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [MODE_W-1:0]    mode;
    logic [SEQ_W-1:0]     seq_number;
    logic [TIME_W-1:0]    time_us;
    logic                 out_valid;
    logic                 out_ready;
    logic                 accepted;
    logic [DLY_W-1:0]     delay_us;
    logic [CNT_OUT_W-1:0] sent_count;
    logic [CNT_OUT_W-1:0] reply_count;
    logic [DLY_W-1:0]     min_delay_us;
    logic [DLY_W-1:0]     max_delay_us;
    logic [DLY_W-1:0]     mean_delay_us;
    logic [DLY_W-1:0]     mean_deviation_us;
    logic [LOSS_W-1:0]    loss_percent;

    int mismatch_total;
    int pending_results;
    int stored_sends;
    int refused_sends;
    int matched_replies;
    int summaries_seen;

    bit                calm;
    int                transactions;
    logic [TIME_W-1:0] clock_us;
    logic [SEQ_W-1:0]  sent_seq_q [$];
    logic [TIME_W-1:0] sent_time_q [$];

    echo_rtt_tracker_unit #(
        .MAX_PINGS(MAX_PINGS)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .mode              (mode),
        .seq_number        (seq_number),
        .time_us           (time_us),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .accepted          (accepted),
        .delay_us          (delay_us),
        .sent_count        (sent_count),
        .reply_count       (reply_count),
        .min_delay_us      (min_delay_us),
        .max_delay_us      (max_delay_us),
        .mean_delay_us     (mean_delay_us),
        .mean_deviation_us (mean_deviation_us),
        .loss_percent      (loss_percent)
    );

    echo_rtt_tracker_checker #(
        .MAX_PINGS(MAX_PINGS)
    ) u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .mode              (mode),
        .seq_number        (seq_number),
        .time_us           (time_us),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .accepted          (accepted),
        .delay_us          (delay_us),
        .sent_count        (sent_count),
        .reply_count       (reply_count),
        .min_delay_us      (min_delay_us),
        .max_delay_us      (max_delay_us),
        .mean_delay_us     (mean_delay_us),
        .mean_deviation_us (mean_deviation_us),
        .loss_percent      (loss_percent),
        .mismatch_total    (mismatch_total),
        .pending_results   (pending_results),
        .stored_sends      (stored_sends),
        .refused_sends     (refused_sends),
        .matched_replies   (matched_replies),
        .summaries_seen    (summaries_seen)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("Timed out with %0d results outstanding", pending_results);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [TIME_W-1:0] rand_time();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Call at a falling edge; returns at a falling edge after the transaction.
    task automatic offer(logic [MODE_W-1:0] m, logic [SEQ_W-1:0] s, logic [TIME_W-1:0] t);
        in_valid   <= 1'b1;
        mode       <= m;
        seq_number <= s;
        time_us    <= t;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        transactions++;
        if (m == MODE_SEND && sent_seq_q.size() < MAX_PINGS) begin
            sent_seq_q.push_back(s);
            sent_time_q.push_back(t);
        end
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
    endtask

    task automatic random_event(int send_weight);
        int                pick;
        int                k;
        logic [SEQ_W-1:0]  s;
        logic [TIME_W-1:0] t;
        pick = $urandom_range(0, 99);
        if (pick < send_weight) begin
            if ($urandom_range(0, 4) == 0) begin
                t = rand_time();
            end else begin
                clock_us += TIME_W'($urandom_range(1, 5000));
                t = clock_us;
            end
            if (sent_seq_q.size() > 0 && $urandom_range(0, 3) == 0)
                s = sent_seq_q[$urandom_range(0, sent_seq_q.size() - 1)];
            else
                s = 16'($urandom);
            offer(MODE_SEND, s, t);
        end else if (pick < send_weight + 60) begin
            if (sent_seq_q.size() > 0 && $urandom_range(0, 3) != 0) begin
                k = $urandom_range(0, sent_seq_q.size() - 1);
                s = sent_seq_q[k];
                case ($urandom_range(0, 9))
                    7:       t = sent_time_q[k] - TIME_W'($urandom_range(1, 1000));
                    8:       t = sent_time_q[k] + 48'h1_0000_0000 + TIME_W'($urandom);
                    9:       t = rand_time();
                    default: t = sent_time_q[k] + TIME_W'($urandom_range(0, 20000));
                endcase
            end else begin
                s = 16'($urandom);
                t = rand_time();
            end
            offer(MODE_REPLY, s, t);
        end else if (pick < 95) begin
            offer(MODE_SUMMARY, 16'($urandom), rand_time());
        end else begin
            offer(MODE_UNUSED, 16'($urandom), rand_time());
        end
    endtask

    initial begin
        int stretch;
        out_ready = 1'b0;
        stretch   = 0;
        forever begin
            @(negedge clk);
            if (calm) begin
                out_ready <= 1'b1;
            end else if (stretch > 0) begin
                stretch--;
            end else if ($urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                stretch = $urandom_range(0, 14);
            end else begin
                out_ready <= 1'b1;
                stretch = $urandom_range(0, 39);
            end
        end
    end

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_SEND;
        seq_number   = '0;
        time_us      = '0;
        calm         = 1'b0;
        transactions = 0;
        clock_us     = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table, unknown reply, unused mode
        offer(MODE_SUMMARY, 16'h0000, '0);
        offer(MODE_REPLY, 16'h0000, '0);
        offer(MODE_UNUSED, 16'hFFFF, TIME_TOP);
        // field extremes and a repeated sequence number
        offer(MODE_SEND, 16'h0000, '0);
        offer(MODE_SEND, 16'hFFFF, TIME_TOP);
        offer(MODE_SEND, 16'h1234, 48'd1000);
        offer(MODE_SEND, 16'h1234, 48'd2000);
        offer(MODE_SUMMARY, 16'hFFFF, TIME_TOP);
        offer(MODE_REPLY, 16'h1234, 48'd2500);
        offer(MODE_REPLY, 16'h1234, 48'd2100);
        offer(MODE_REPLY, 16'h1234, 48'd3000);
        // reply before send time, then a delay past 32 bits
        offer(MODE_REPLY, 16'hFFFF, 48'd5);
        offer(MODE_REPLY, 16'h0000, TIME_TOP);
        offer(MODE_SUMMARY, 16'h0000, '0);
        offer(MODE_SEND, 16'h5555, 48'h8000_0000_0000);
        offer(MODE_REPLY, 16'h5555, 48'h8000_0000_0000);
        offer(MODE_SEND, 16'hAAAA, 48'h5555_5555_5555);
        offer(MODE_REPLY, 16'hAAAA, 48'h5555_5556_0000);
        offer(MODE_REPLY, 16'hAAAA, 48'h5555_5556_0000);
        offer(MODE_SUMMARY, 16'hAAAA, 48'hAAAA_AAAA_AAAA);

        repeat (900)
            random_event(10);

        // fill the table, then hit it with refused sends and final statistics
        calm = 1'b1;
        while (sent_seq_q.size() < MAX_PINGS)
            random_event(100);
        repeat (40)
            random_event(30);
        offer(MODE_SUMMARY, 16'h0000, '0);
        in_valid <= 1'b0;

        while (pending_results != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);

        $display("Ran %0d transactions: %0d sends stored, %0d refused on a full table,",
                 transactions, stored_sends, refused_sends);
        $display("%0d replies matched, %0d summaries checked, %0d mismatches.",
                 matched_replies, summaries_seen, mismatch_total);
        if (mismatch_total == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
